// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every edge outside reset
`define BRA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bra assertion failed");

// implication checked at every edge, reset included
`define BRA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bra assertion failed");

`endif

// ----- src/bra_pkg.sv -----
// types, codes and command structs of the bitmap region allocator
// no dependencies
package bra_pkg;

   localparam int POS_W = 11;

   typedef enum logic [2:0] {
      ACT_FIND_SET    = 3'd0,
      ACT_FIND_CLEAR  = 3'd1,
      ACT_SET_RANGE   = 3'd2,
      ACT_CLEAR_RANGE = 3'd3,
      ACT_ALLOC_AT    = 3'd4,
      ACT_ALLOC_FREE  = 3'd5
   } bra_action_type;

   typedef struct packed {
      logic [2:0]       action;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] length;
      logic [POS_W-1:0] limit;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0] index;
      logic             status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FIND,
      ST_CHECK,
      ST_CAND_TEST,
      ST_FILL
   } bra_state_type;

   typedef enum logic [1:0] {
      BND_FIND,
      BND_POS,
      BND_CAND
   } bra_bound_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_ZERO,
      CUR_MARK,
      CUR_NEXT
   } bra_cur_op_type;

   typedef enum logic [2:0] {
      RES_ZERO_OK,
      RES_ZERO_BAD,
      RES_FOUND,
      RES_LIMIT,
      RES_POS_OK,
      RES_POS_BUSY,
      RES_CAND_OK
   } bra_res_type;

   typedef struct packed {
      logic           load;
      logic           set_bounds;
      bra_bound_type  bound_sel;
      bra_cur_op_type cur_op;
      logic           take_mark;
      logic           write;
      logic           cand_next;
      logic           res_load;
      bra_res_type    res_kind;
   } bra_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       hit;
      logic       pass_end;
      logic       cand_fits;
      logic       len_zero;
      logic       rsp_full;
   } bra_stat_type;

endpackage

// ----- src/bitmap_region_allocator.sv -----
// bitmap region allocator top level: controller plus datapath
// depends on bra_pkg, bra_ctrl, bra_datapath
//
// usage
// - req channel carries one word per operation: action, position, length, limit
// - rsp channel returns exactly one word per request: index and status
// - both channels are valid/stall; a word moves when valid is high and stall low
// - one request is worked on at a time; req_stall stays high from acceptance
//   until the response word has left the output register
// - a request passes a dispatch step, then walks the map words; a walk that ends
//   without a hit loads its result in a final step; searches and range writes start
//   at word 0 and visit at most MAP_BITS/WORD_BITS words
// - the next request is taken once rsp_valid has dropped, which needs rsp_stall low
// - allocate at takes a check walk and, if the range is free, a write walk; allocate free
//   checks candidates in rising order, continuing from the word where the previous
//   candidate failed, with a test step per candidate tried and a write walk for a fit
// - the map word read each cycle by the scan sets the rate
// - reset clears the whole map (every bit free) and drops any pending response
// - a stalled response holds in the output register; nothing else is lost
module bitmap_region_allocator
   import bra_pkg::*;
#(
   parameter int MAP_BITS  = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   // command and status between sequencer and datapath
   bra_cmd_type  cmd;
   bra_stat_type stat;

   // state machine: dispatch, scan walks, candidate stepping
   bra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // map storage, masked word compare, priority encode, response register
   bra_datapath #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/bra_ctrl.sv -----
// controller state machine of the bitmap region allocator
// depends on bra_pkg
module bra_ctrl
   import bra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bra_stat_type stat,
   output bra_cmd_type  cmd
);

   bra_state_type state_ff, state_in;
   logic          accept;

   assign req_stall = !(state_ff == ST_IDLE && !stat.rsp_full);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (stat.action)
               ACT_FIND_SET, ACT_FIND_CLEAR: state_in = ST_FIND;
               ACT_SET_RANGE, ACT_CLEAR_RANGE: state_in = ST_FILL;
               ACT_ALLOC_AT: state_in = ST_CHECK;
               ACT_ALLOC_FREE: begin
                  if (stat.len_zero || !stat.cand_fits) state_in = ST_IDLE;
                  else state_in = ST_CHECK;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FIND: begin
            if (stat.hit || stat.pass_end) state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (stat.hit) begin
               if (stat.action == ACT_ALLOC_AT) state_in = ST_IDLE;
               else state_in = ST_CAND_TEST;
            end else if (stat.pass_end) begin
               state_in = ST_FILL;
            end
         end
         ST_CAND_TEST: begin
            if (stat.cand_fits) state_in = ST_CHECK;
            else state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (stat.pass_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.bound_sel = BND_FIND;
      cmd.cur_op    = CUR_HOLD;
      cmd.res_kind  = RES_ZERO_OK;
      cmd.load      = accept;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_DISPATCH: begin
            cmd.set_bounds = 1'b1;
            cmd.cur_op     = CUR_ZERO;
            cmd.take_mark  = 1'b1;
            case (stat.action)
               ACT_FIND_SET, ACT_FIND_CLEAR: cmd.bound_sel = BND_FIND;
               ACT_SET_RANGE, ACT_CLEAR_RANGE, ACT_ALLOC_AT: cmd.bound_sel = BND_POS;
               ACT_ALLOC_FREE: begin
                  cmd.bound_sel = BND_CAND;
                  if (stat.len_zero) begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_ZERO_OK;
                  end else if (!stat.cand_fits) begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_LIMIT;
                  end
               end
               default: begin
                  cmd.res_load = 1'b1;
                  cmd.res_kind = RES_ZERO_BAD;
               end
            endcase
         end
         ST_FIND: begin
            if (stat.hit) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_FOUND;
            end else if (stat.pass_end) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_LIMIT;
            end else begin
               cmd.cur_op = CUR_NEXT;
            end
         end
         ST_CHECK: begin
            if (stat.hit) begin
               if (stat.action == ACT_ALLOC_AT) begin
                  cmd.res_load = 1'b1;
                  cmd.res_kind = RES_POS_BUSY;
               end else begin
                  cmd.cand_next = 1'b1;
               end
            end else if (stat.pass_end) begin
               cmd.cur_op = CUR_MARK;
            end else begin
               cmd.cur_op = CUR_NEXT;
            end
         end
         ST_CAND_TEST: begin
            if (stat.cand_fits) begin
               cmd.set_bounds = 1'b1;
               cmd.bound_sel  = BND_CAND;
               cmd.take_mark  = 1'b1;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_LIMIT;
            end
         end
         ST_FILL: begin
            if (stat.pass_end) begin
               cmd.res_load = 1'b1;
               case (stat.action)
                  ACT_ALLOC_AT: cmd.res_kind = RES_POS_OK;
                  ACT_ALLOC_FREE: cmd.res_kind = RES_CAND_OK;
                  default: cmd.res_kind = RES_ZERO_OK;
               endcase
            end else begin
               cmd.write  = 1'b1;
               cmd.cur_op = CUR_NEXT;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- src/bra_datapath.sv -----
// map storage, word scan and result register of the bitmap region allocator
// depends on bra_pkg
module bra_datapath
   import bra_pkg::*;
#(
   parameter int MAP_BITS  = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  bra_cmd_type  cmd,
   output bra_stat_type stat,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int LOG_W     = $clog2(WORD_BITS);
   localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CUR_W     = (LOG_W + WA_W + 1 > POS_W + 2) ? LOG_W + WA_W + 1 : POS_W + 2;
   localparam logic [CUR_W-1:0] MAP_LIM  = CUR_W'(MAP_BITS);
   localparam logic [CUR_W-1:0] WORD_INC = CUR_W'(WORD_BITS);

   logic [2:0]           act_ff;
   logic [POS_W-1:0]     pos_ff, len_ff, lim_ff, cand_ff, cand_in;
   logic [CUR_W-1:0]     lo_ff, hi_ff, lo_in, hi_in;
   logic [CUR_W-1:0]     cur_ff, cur_in, mark_cur_ff;
   logic [WA_W:0]        widx_ff, widx_in, mark_widx_ff;
   logic [WORD_BITS-1:0] map_ff [NUM_WORDS];
   logic [WORD_BITS-1:0] word, mask, hitvec;
   logic [LOG_W-1:0]     enc;
   logic [POS_W:0]       cand_end;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_data_ff, res;

   assign word     = map_ff[widx_ff[WA_W-1:0]];
   assign cand_end = {1'b0, cand_ff} + {1'b0, len_ff};

   // bits of the current word inside [lo, hi) and inside the map
   always_comb begin
      logic [CUR_W-1:0] g;
      g = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         g       = cur_ff + CUR_W'(b);
         mask[b] = (g >= lo_ff) && (g < hi_ff) && (g < MAP_LIM);
      end
   end

   assign hitvec = ((act_ff == ACT_FIND_CLEAR) ? ~word : word) & mask;

   // lowest hit bit
   always_comb begin
      enc = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (hitvec[b]) enc = LOG_W'(b);
      end
   end

   assign stat.action    = act_ff;
   assign stat.hit       = |hitvec;
   assign stat.pass_end  = (cur_ff >= hi_ff) || (cur_ff >= MAP_LIM);
   assign stat.cand_fits = cand_end <= {1'b0, lim_ff};
   assign stat.len_zero  = (len_ff == '0);
   assign stat.rsp_full  = rsp_valid_ff;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      case (cmd.bound_sel)
         BND_FIND: begin
            lo_in = CUR_W'(pos_ff);
            hi_in = CUR_W'(lim_ff);
         end
         BND_POS: begin
            lo_in = CUR_W'(pos_ff);
            hi_in = CUR_W'(pos_ff) + CUR_W'(len_ff);
         end
         BND_CAND: begin
            lo_in = CUR_W'(cand_ff);
            hi_in = CUR_W'(cand_end);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      widx_in = widx_ff;
      case (cmd.cur_op)
         CUR_ZERO: begin
            cur_in  = '0;
            widx_in = '0;
         end
         CUR_MARK: begin
            cur_in  = mark_cur_ff;
            widx_in = mark_widx_ff;
         end
         CUR_NEXT: begin
            cur_in  = cur_ff + WORD_INC;
            widx_in = widx_ff + (WA_W+1)'(1);
         end
         default: begin
         end
      endcase
   end

   assign cand_in = cmd.load ? '0 : (cmd.cand_next ? POS_W'(cand_end) : cand_ff);

   always_comb begin
      res = '0;
      case (cmd.res_kind)
         RES_ZERO_OK:  res = '{index: '0, status: 1'b0};
         RES_ZERO_BAD: res = '{index: '0, status: 1'b1};
         RES_FOUND:    res = '{index: POS_W'(cur_ff + CUR_W'(enc)), status: 1'b0};
         RES_LIMIT:    res = '{index: lim_ff, status: 1'b1};
         RES_POS_OK:   res = '{index: pos_ff, status: 1'b0};
         RES_POS_BUSY: res = '{index: pos_ff, status: 1'b1};
         RES_CAND_OK:  res = '{index: cand_ff, status: 1'b0};
         default:      res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_data.action;
         pos_ff <= req_data.position;
         len_ff <= req_data.length;
         lim_ff <= req_data.limit;
      end
      if (cmd.set_bounds) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.take_mark) begin
         mark_cur_ff  <= cur_in;
         mark_widx_ff <= widx_in;
      end
      cand_ff <= cand_in;
      cur_ff  <= cur_in;
      widx_ff <= widx_in;
      if (cmd.res_load) rsp_data_ff <= res;
   end

   // map words, all free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) map_ff[w] <= '0;
      end else if (cmd.write) begin
         if (act_ff == ACT_CLEAR_RANGE) map_ff[widx_ff[WA_W-1:0]] <= word & ~mask;
         else map_ff[widx_ff[WA_W-1:0]] <= word | mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/bra_checker.sv -----
// port-level checks of the bitmap region allocator, bound to the top level
// depends on bra_pkg and assert_macros.svh
`include "assert_macros.svh"

module bra_checker
   import bra_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   `BRA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `BRA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `BRA_ASSERT(a_busy_while_rsp, clock, reset, rsp_valid |-> req_stall)
   `BRA_ASSERT(a_no_rsp_after_req, clock, reset, req_valid && !req_stall |=> !rsp_valid)

endmodule

bind bitmap_region_allocator bra_checker u_bra_checker (.*);
